[sv/bfdh_pkg.sv]
// ---------------------------------------------------------------------------
// bfdh_pkg
// Shared types and constants for the double-hashing Bloom filter unit.
// ---------------------------------------------------------------------------
package bfdh_pkg;

  // Field widths
  localparam int HASH_W       = 64;
  localparam int NUM_BITS_W   = 17;
  localparam int NUM_HASHES_W = 8;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 17;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_NUM_BITS   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES = 8'd1;

  // Register reset values
  localparam logic [NUM_BITS_W-1:0]   NUM_BITS_RST   = 17'h10000;
  localparam logic [NUM_HASHES_W-1:0] NUM_HASHES_RST = 8'd1;

  // Command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  // Remainder unit: two dividend bits per step
  localparam int REM_STEPS  = HASH_W / 2;
  localparam int REM_STEP_W = $clog2(REM_STEPS);

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One queued request, already classified
  typedef struct packed {
    logic              cmd;
    logic [HASH_W-1:0] hash_a;
    logic [HASH_W-1:0] hash_b;
    logic              no_probe;
  } bfdh_entry_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_PROBE,
    ST_FINISH
  } bfdh_state_t;

endpackage

[sv/bfdh_rem.sv]
// ---------------------------------------------------------------------------
// bfdh_rem
// Serial remainder unit: 64-bit dividend modulo a narrow divisor, two
// dividend bits per cycle, restoring compare and subtract.
// ---------------------------------------------------------------------------
module bfdh_rem
  import bfdh_pkg::*;
#(
  parameter int MW = 17
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [HASH_W-1:0] dividend,
  input  logic [MW-1:0]     divisor,
  output logic [MW-1:0]     rem,
  output logic              done
);

  logic [HASH_W-1:0]     sh_r;
  logic [MW-1:0]         acc_r;
  logic [MW-1:0]         acc_nxt;
  logic [REM_STEP_W-1:0] step_r;
  logic                  busy_r;
  logic                  done_r;
  logic [MW:0]           t1;
  logic [MW:0]           t2;

  // Two restoring steps per cycle; acc stays below divisor
  always_comb begin
    t1 = {acc_r, sh_r[HASH_W-1]};
    if (t1 >= {1'b0, divisor}) begin
      t1 = t1 - {1'b0, divisor};
    end
    t2 = {t1[MW-1:0], sh_r[HASH_W-2]};
    if (t2 >= {1'b0, divisor}) begin
      t2 = t2 - {1'b0, divisor};
    end
    acc_nxt = t2[MW-1:0];
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == REM_STEP_W'(REM_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= dividend;
      acc_r <= '0;
    end else if (busy_r) begin
      sh_r  <= {sh_r[HASH_W-3:0], 2'b00};
      acc_r <= acc_nxt;
    end
  end

  assign rem  = acc_r;
  assign done = done_r;

endmodule

[sv/bfdh_front.sv]
// ---------------------------------------------------------------------------
// bfdh_front
// Request intake: accepts input items, flags those with no probes and
// holds them in a short queue for the back end.
// ---------------------------------------------------------------------------
module bfdh_front
  import bfdh_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_cmd,
  input  logic [HASH_W-1:0]       in_hash_a,
  input  logic [HASH_W-1:0]       in_hash_b,
  input  logic [NUM_HASHES_W-1:0] num_hashes,
  input  logic                    clearing,
  output logic                    q_valid,
  output bfdh_entry_t             q_entry,
  input  logic                    q_pop
);

  bfdh_entry_t         queue_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                push;
  bfdh_entry_t         new_entry;

  // No requests are taken during the store clear after reset
  assign in_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH)) && !clearing;
  assign push     = in_valid && in_ready;

  // Classify the incoming request
  always_comb begin
    new_entry.cmd      = in_cmd;
    new_entry.hash_a   = in_hash_a;
    new_entry.hash_b   = in_hash_b;
    new_entry.no_probe = (num_hashes == '0);
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= new_entry;
    end
  end

  assign q_valid = (cnt_r != '0);
  assign q_entry = queue_r[rd_ptr_r];

endmodule

[sv/bfdh_back.sv]
// ---------------------------------------------------------------------------
// bfdh_back
// Probe engine: reduces the hash halves modulo the filter size, walks the
// probe sequence over the bit store and drives the result register.
// ---------------------------------------------------------------------------
module bfdh_back
  import bfdh_pkg::*;
#(
  parameter  int MAX_BITS = 65536,
  localparam int MW       = $clog2(MAX_BITS + 1),
  localparam int AW       = $clog2(MAX_BITS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  bfdh_entry_t             q_entry,
  output logic                    q_pop,
  input  logic [MW-1:0]           m,
  input  logic [NUM_HASHES_W-1:0] num_hashes,
  output logic                    clearing,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_present
);

  bfdh_state_t             state_r;
  bfdh_state_t             state_nxt;
  logic [AW-1:0]           clr_addr_r;
  logic                    cmd_r;
  logic [HASH_W-1:0]       v_r;
  logic [HASH_W-1:0]       b_r;
  logic [MW-1:0]           r_r;
  logic [MW-1:0]           bm_r;
  logic [MW-1:0]           k_r;
  logic [MW-1:0]           d_r;
  logic [NUM_HASHES_W-1:0] cnt_r;
  logic                    hit_r;
  logic                    rd_vld_r;
  logic                    rd_bit_r;
  logic                    out_valid_r;
  logic                    out_present_r;
  logic                    bit_mem [MAX_BITS];

  logic                    rem_start;
  logic                    rem_done;
  logic                    rem_done_b;
  logic                    rem_done_k;
  logic [MW-1:0]           rem_a;
  logic [MW-1:0]           rem_b;
  logic [MW-1:0]           rem_ones;

  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic                    mem_wdata;
  logic                    last_probe;
  logic                    out_free;
  logic                    present_now;
  logic                    out_load;

  logic [HASH_W:0]         vsum;
  logic [MW:0]             rsum;
  logic [MW-1:0]           r_step;
  logic [MW:0]             kinc;
  logic [MW-1:0]           k_val;
  logic [MW-1:0]           d_val;

  // Residues of hash_a, hash_b and 2^64-1
  bfdh_rem #(.MW(MW)) u_rem_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (q_entry.hash_a),
    .divisor  (m),
    .rem      (rem_a),
    .done     (rem_done)
  );

  bfdh_rem #(.MW(MW)) u_rem_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (q_entry.hash_b),
    .divisor  (m),
    .rem      (rem_b),
    .done     (rem_done_b)
  );

  bfdh_rem #(.MW(MW)) u_rem_k (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend ({HASH_W{1'b1}}),
    .divisor  (m),
    .rem      (rem_ones),
    .done     (rem_done_k)
  );

  // Wrap correction: K = 2^64 mod m, D = (b - K) mod m
  always_comb begin
    kinc  = {1'b0, rem_ones} + 1'b1;
    k_val = (kinc == {1'b0, m}) ? '0 : kinc[MW-1:0];
    d_val = (bm_r >= k_r) ? bm_r - k_r : MW'({1'b0, bm_r} + {1'b0, m} - {1'b0, k_r});
  end

  // Next probe: v += b; residue advances by b mod m, or by D on 64-bit wrap
  always_comb begin
    vsum   = {1'b0, v_r} + {1'b0, b_r};
    rsum   = {1'b0, r_r} + {1'b0, (vsum[HASH_W] ? d_r : bm_r)};
    r_step = (rsum >= {1'b0, m}) ? MW'(rsum - {1'b0, m}) : rsum[MW-1:0];
  end

  assign last_probe  = (cnt_r == num_hashes - 1'b1);
  assign out_free    = !out_valid_r || out_ready;
  assign present_now = hit_r && (!rd_vld_r || rd_bit_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(MAX_BITS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = q_entry.no_probe ? ST_FINISH : ST_DIV;
        end
      end
      ST_DIV: begin
        if (rem_done && rem_done_b && rem_done_k) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = ST_PROBE;
      end
      ST_PROBE: begin
        if (last_probe) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (cmd_r == CMD_INSERT || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop     = 1'b0;
    rem_start = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = r_r[AW-1:0];
    mem_wdata = 1'b1;
    out_load  = 1'b0;
    clearing  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        clearing  = 1'b1;
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = 1'b0;
      end
      ST_IDLE: begin
        q_pop     = q_valid;
        rem_start = q_valid && !q_entry.no_probe;
      end
      ST_PROBE: begin
        mem_we = (cmd_r == CMD_INSERT);
      end
      ST_FINISH: begin
        out_load = (cmd_r == CMD_QUERY) && out_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= (state_r == ST_PROBE) && (cmd_r == CMD_QUERY);
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Probe datapath
  always_ff @(posedge clk) begin
    if (rd_vld_r) begin
      hit_r <= hit_r && rd_bit_r;
    end
    case (state_r)
      ST_IDLE: begin
        cmd_r <= q_entry.cmd;
        v_r   <= q_entry.hash_a;
        b_r   <= q_entry.hash_b;
        cnt_r <= '0;
        hit_r <= 1'b1;
      end
      ST_DIV: begin
        r_r  <= rem_a;
        bm_r <= rem_b;
        k_r  <= k_val;
      end
      ST_PREP: begin
        d_r <= d_val;
      end
      ST_PROBE: begin
        v_r   <= vsum[HASH_W-1:0];
        r_r   <= r_step;
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
    if (out_load) begin
      out_present_r <= present_now;
    end
  end

  // Bit store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      bit_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_bit_r <= bit_mem[r_r[AW-1:0]];
  end

  assign out_valid   = out_valid_r;
  assign out_present = out_present_r;

endmodule

[sv/bloom_filter_double_hash_unit.sv]
// ---------------------------------------------------------------------------
// bloom_filter_double_hash_unit
// Bloom filter with double hashing over a bit store of MAX_BITS entries.
// ---------------------------------------------------------------------------
//  Channel  Direction  Handshake               Payload
//  in_      input      in_valid / in_ready     in_cmd, in_hash_a, in_hash_b
//  out_     output     out_valid / out_ready   out_present (queries only)
//  cfg_     input      cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  For an item with h probes, three serial remainder units reduce hash_a,
//  hash_b and 2^64-1 modulo the size at two bits a cycle, then one probe a
//  cycle goes to the bit store; an item with h = 0 skips both. After reset
//  the store is cleared one bit a cycle, and no request is taken until then.
//  A two-entry queue keeps intake running while the engine works; a held
//  result stalls only the next query's finish.
// ---------------------------------------------------------------------------
module bloom_filter_double_hash_unit
  import bfdh_pkg::*;
#(
  parameter int MAX_BITS = 65536
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_cmd,
  input  logic [HASH_W-1:0]     in_hash_a,
  input  logic [HASH_W-1:0]     in_hash_b,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_present,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MW = $clog2(MAX_BITS + 1);

  logic [NUM_BITS_W-1:0]   num_bits_r;
  logic [NUM_HASHES_W-1:0] num_hashes_r;
  logic [MW-1:0]           m_eff;
  logic                    clearing;
  logic                    q_valid;
  logic                    q_pop;
  bfdh_entry_t             q_entry;

  assign cfg_ready = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bits_r   <= NUM_BITS_RST;
      num_hashes_r <= NUM_HASHES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NUM_BITS:   num_bits_r   <= cfg_data[NUM_BITS_W-1:0];
        REG_NUM_HASHES: num_hashes_r <= cfg_data[NUM_HASHES_W-1:0];
        default:        num_bits_r   <= num_bits_r;
      endcase
    end
  end

  // Effective modulus: zero reads as one, saturate at the store size
  always_comb begin
    if (32'(num_bits_r) > 32'(MAX_BITS)) begin
      m_eff = MW'(MAX_BITS);
    end else if (num_bits_r == '0) begin
      m_eff = MW'(1);
    end else begin
      m_eff = MW'(num_bits_r);
    end
  end

  bfdh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_hash_a  (in_hash_a),
    .in_hash_b  (in_hash_b),
    .num_hashes (num_hashes_r),
    .clearing   (clearing),
    .q_valid    (q_valid),
    .q_entry    (q_entry),
    .q_pop      (q_pop)
  );

  bfdh_back #(.MAX_BITS(MAX_BITS)) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_entry     (q_entry),
    .q_pop       (q_pop),
    .m           (m_eff),
    .num_hashes  (num_hashes_r),
    .clearing    (clearing),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_present (out_present)
  );

endmodule
